// ===== hdl/sdaf_pkg.sv =====
// Shared types and constants for the signed decimal ASCII formatter.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package sdaf_pkg;

  localparam int CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic shift_digit;
    logic sel_sign;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic one_left;
    logic negative;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/signed_decimal_ascii_formatter.sv =====
// Top level of the signed decimal ASCII formatter.
// Depends on sdaf_pkg, sdaf_ctrl and sdaf_datapath.
//
// Usage:
//   Slave stream s_*: one word carries a signed two's-complement value in
//   s_tdata[VALUE_WIDTH-1:0], zero-padded to whole bytes.
//   Master stream m_*: one word per character, most significant digit first,
//   '-' leading for negative values; m_tlast marks the final character.
//   Zero gives the single character '0'; the most negative value is exact.
// Timing:
//   s_tready is high only while idle. After a word is accepted, the
//   bit-serial BCD conversion runs over all VALUE_WIDTH bits (one bit per
//   cycle through the shift register), then leading zero digits are skipped
//   and the first character is picked, then one character per cycle is
//   offered while m_tready is high.
// Reset (rst, synchronous) returns the controller to idle and drops any
// number in progress. A stall on m_tready holds the current character;
// no new word is taken until the last character is delivered.
`default_nettype none
module signed_decimal_ascii_formatter import sdaf_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // fields from bit 0: value[VALUE_WIDTH-1:0], zero pad
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]  s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // fields from bit 0: char_code[6:0], zero pad
  output logic [7:0]                             m_tdata,
  // is_last
  output logic                                   m_tlast
);

  cmd_t              cmd;
  status_t           status;
  logic [CHAR_W-1:0] char_code;

  sdaf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sdaf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .value     (s_tdata[VALUE_WIDTH-1:0]),
    .cmd       (cmd),
    .status    (status),
    .char_code (char_code),
    .is_last   (m_tlast)
  );

  assign m_tdata = {1'b0, char_code};

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a character is offered");

  a_convert_gap: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid)
    else $error("character offered right after accept");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("not idle after final character");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == 8'd45 || (m_tdata >= 8'd48 && m_tdata <= 8'd57)))
    else $error("bad character code");

endmodule
`default_nettype wire

// ===== hdl/sdaf_datapath.sv =====
// Datapath: magnitude, bit-serial binary-to-BCD shift register, digit counter
// and output character mux. Depends on sdaf_pkg.
`default_nettype none
module sdaf_datapath import sdaf_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  output logic [CHAR_W-1:0]           char_code,
  output logic                        is_last
);

  localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int CW   = $clog2(VALUE_WIDTH);
  localparam int RW   = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] mag;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          bcd_adj;
  logic [CW-1:0]          cnt;
  logic [RW-1:0]          remaining;
  logic                   negative;
  logic [3:0]             top;

  // add-3 correction on every digit before each shift
  always_comb begin
    logic [3:0] nib;
    nib = 4'd0;
    for (int i = 0; i < NDIG; i++) begin
      nib = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative  <= value[VALUE_WIDTH-1];
      mag       <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
      bcd       <= '0;
      cnt       <= '0;
      remaining <= RW'(NDIG);
    end else if (cmd.conv_step) begin
      bcd <= {bcd_adj[BW-2:0], mag[VALUE_WIDTH-1]};
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      cnt <= cnt + CW'(1);
    end else if (cmd.shift_digit) begin
      bcd       <= {bcd[BW-5:0], 4'd0};
      remaining <= remaining - RW'(1);
    end
  end

  assign top              = bcd[BW-1 -: 4];
  assign status.conv_done = (cnt == CW'(VALUE_WIDTH - 1));
  assign status.top_zero  = (top == 4'd0);
  assign status.one_left  = (remaining == RW'(1));
  assign status.negative  = negative;

  assign char_code = cmd.sel_sign ? CHAR_MINUS : CHAR_ZERO + {3'd0, top};
  assign is_last   = !cmd.sel_sign && status.one_left;

endmodule
`default_nettype wire

// ===== hdl/sdaf_ctrl.sv =====
// Controller state machine: accept, convert, skip leading zeros, emit.
// Depends on sdaf_pkg.
`default_nettype none
module sdaf_ctrl import sdaf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (status.conv_done) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if (!(status.top_zero && !status.one_left)) begin
          state_next = status.negative ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_ready) state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_ready && status.one_left) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd.load        = 1'b0;
    cmd.conv_step   = 1'b0;
    cmd.shift_digit = 1'b0;
    cmd.sel_sign    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONVERT: begin
        cmd.conv_step = 1'b1;
      end
      ST_SKIP: begin
        cmd.shift_digit = status.top_zero && !status.one_left;
      end
      ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.sel_sign = 1'b1;
      end
      ST_DIGIT: begin
        out_valid       = 1'b1;
        cmd.shift_digit = out_ready;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
